/* rtl/mrpt_pkg.sv */
// Package with shared constants for the primality tester.
`default_nettype none
package mrpt_pkg;
    localparam int NUMBER_WIDTH_DEFAULT = 31;
    localparam logic [5:0] BASE_COUNT_RESET = 6'd20;
    localparam int FIRST_BASE = 2;
    localparam int ADDR_BASE_COUNT = 0;
endpackage
`default_nettype wire

/* rtl/mrpt_cell.sv */
// One cell of the bit-serial modular multiplier chain: a doubling and add step.
`default_nettype none
module mrpt_cell #(
    parameter int W = mrpt_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] n,
    input  wire logic [W-1:0] acc_in,
    input  wire logic [W-1:0] x_in,
    input  wire logic         bit_in,
    output logic [W-1:0]      acc_out,
    output logic [W-1:0]      x_out
);
    import mrpt_pkg::*;
    logic [W:0] sum;
    logic [W:0] dbl;
    logic [W-1:0] acc_next;
    logic [W-1:0] x_next;
    logic [W-1:0] acc_reg;
    logic [W-1:0] x_reg;

    always_comb
    begin
        sum = {1'b0, acc_in} + {1'b0, x_in};
        if (!bit_in)
        begin
            acc_next = acc_in;
        end
        else if (sum >= {1'b0, n})
        begin
            acc_next = W'(sum - {1'b0, n});
        end
        else
        begin
            acc_next = sum[W-1:0];
        end
        dbl = {x_in, 1'b0};
        if (dbl >= {1'b0, n})
        begin
            x_next = W'(dbl - {1'b0, n});
        end
        else
        begin
            x_next = dbl[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
        end
    end

    assign acc_out = acc_reg;
    assign x_out   = x_reg;
endmodule
`default_nettype wire

/* rtl/mrpt_mulchain.sv */
// Modular multiplier built as a chain of cells, one multiplier bit per cell.
`default_nettype none
module mrpt_mulchain #(
    parameter int W = mrpt_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] n,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic [W-1:0]      product
);
    import mrpt_pkg::*;
    logic [W-1:0] acc_c [W+1];
    logic [W-1:0] x_c [W+1];
    logic [W-1:0] b_reg;
    logic [W-1:0] b_next;
    logic [W:0]   run_reg;
    logic [W:0]   run_next;
    logic [W-1:0] b_sh [W];

    assign acc_c[0] = '0;
    assign x_c[0]   = a;

    genvar g;
    generate
        for (g = 0; g < W; g++)
        begin : g_cell
            assign b_sh[g] = b_reg >> g;
            mrpt_cell #(.W(W)) u_cell (
                .clk    (clk),
                .en     (run_reg[g]),
                .n      (n),
                .acc_in (acc_c[g]),
                .x_in   (x_c[g]),
                .bit_in (b_sh[g][0]),
                .acc_out(acc_c[g+1]),
                .x_out  (x_c[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        run_next = {run_reg[W-1:0], start};
        b_next   = start ? b : b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
    end

    assign done    = run_reg[W];
    assign product = acc_c[W];
endmodule
`default_nettype wire

/* rtl/miller_rabin_primality_test.sv */
// Top level of the Miller-Rabin primality tester with its control sequencer.
// One candidate is tested at a time. Each modular product passes through a chain of
// NUMBER_WIDTH cells, one multiplier bit per cell. A base takes about two products per
// exponent bit plus up to r squarings, and a candidate below two skips the products.
// The result is held in an output register until its transfer, while the next
// candidate can already be accepted and tested.
`default_nettype none
module miller_rabin_primality_test #(
    parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [0:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire logic                    candidate_valid,
    output logic                         candidate_ready,
    input  wire logic [NUMBER_WIDTH-1:0] candidate,
    output logic                         is_prime_valid,
    input  wire logic                    is_prime_ready,
    output logic                         is_prime
);
    import mrpt_pkg::*;
    localparam int W = NUMBER_WIDTH;
    localparam int RW = $clog2(W + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BASE  = 4'd1;
    localparam logic [3:0] S_SPLIT = 4'd2;
    localparam logic [3:0] S_EBIT  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SQR   = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_LOOP  = 4'd7;
    localparam logic [3:0] S_LSQ   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [5:0]   base_count_reg, base_count_next;
    logic [3:0]   state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] i_reg, i_next;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [6:0]   k_reg, k_next;
    logic [6:0]   base_reg, base_next;
    logic         prime_reg, prime_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_reg, out_next;
    logic         wait_reg, wait_next;
    logic         start;
    logic [W-1:0] ma, mb;
    logic         mdone;
    logic [W-1:0] mprod;
    logic [6:0]   count;
    logic         cfg_wr;
    logic [W-1:0] nm1;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'(ADDR_BASE_COUNT));
    assign prdata = (paddr == 1'(ADDR_BASE_COUNT)) ? {26'd0, base_count_reg} : 32'd0;
    assign base_count_next = cfg_wr ? pwdata[5:0] : base_count_reg;
    assign count = (base_count_reg == 6'd0) ? 7'd1 : {1'b0, base_count_reg};
    assign nm1 = n_reg - W'(1);

    mrpt_mulchain #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .n      (n_reg),
        .a      (ma),
        .b      (mb),
        .done   (mdone),
        .product(mprod)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; d_next = d_reg; r_next = r_reg; i_next = i_reg;
        e_next = e_reg; b_next = b_reg; acc_next = acc_reg; k_next = k_reg;
        base_next = base_reg; prime_next = prime_reg; wait_next = wait_reg;
        out_valid_next = out_valid_reg; out_next = out_reg;
        start = 1'b0; ma = acc_reg; mb = b_reg;
        if (out_valid_reg && is_prime_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (candidate_valid)
                begin
                    n_next = candidate;
                    k_next = '0;
                    base_next = 7'(FIRST_BASE);
                    b_next = W'(FIRST_BASE);
                    prime_next = (candidate > W'(1));
                    state_next = (candidate > W'(1)) ? S_BASE : S_OUT;
                end
            end
            S_BASE:
            begin
                if (b_reg >= n_reg)
                begin
                    b_next = b_reg - n_reg;
                end
                else if (b_reg <= W'(1))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    d_next = nm1;
                    r_next = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (d_reg[0])
                begin
                    e_next = d_reg;
                    acc_next = W'(1);
                    wait_next = 1'b0;
                    state_next = S_EBIT;
                end
                else
                begin
                    d_next = d_reg >> 1;
                    r_next = r_reg + RW'(1);
                end
            end
            S_EBIT:
            begin
                if (e_reg == '0)
                begin
                    i_next = '0;
                    state_next = S_CHK;
                end
                else if (e_reg[0])
                begin
                    state_next = S_MUL;
                    wait_next = 1'b0;
                end
                else
                begin
                    state_next = S_SQR;
                    wait_next = 1'b0;
                end
            end
            S_MUL:
            begin
                ma = acc_reg; mb = b_reg;
                start = !wait_reg;
                wait_next = 1'b1;
                if (mdone)
                begin
                    acc_next = mprod;
                    wait_next = 1'b0;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                ma = b_reg; mb = b_reg;
                start = !wait_reg;
                wait_next = 1'b1;
                if (mdone)
                begin
                    b_next = mprod;
                    e_next = e_reg >> 1;
                    wait_next = 1'b0;
                    state_next = S_EBIT;
                end
            end
            S_CHK:
            begin
                state_next = (acc_reg == W'(1)) ? S_NEXT : S_LOOP;
            end
            S_LOOP:
            begin
                if (i_reg == r_reg)
                begin
                    prime_next = 1'b0;
                    state_next = S_NEXT;
                end
                else if (acc_reg == nm1)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    wait_next = 1'b0;
                    state_next = S_LSQ;
                end
            end
            S_LSQ:
            begin
                ma = acc_reg; mb = acc_reg;
                start = !wait_reg;
                wait_next = 1'b1;
                if (mdone)
                begin
                    acc_next = mprod;
                    i_next = i_reg + RW'(1);
                    wait_next = 1'b0;
                    state_next = S_LOOP;
                end
            end
            S_NEXT:
            begin
                if (!prime_reg || (k_reg + 7'd1 >= count))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    k_next = k_reg + 7'd1;
                    base_next = base_reg + 7'd1;
                    b_next = W'(base_reg + 7'd1);
                    state_next = S_BASE;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || is_prime_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next = prime_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign candidate_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_count_reg <= BASE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
            wait_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_count_reg <= base_count_next;
            out_valid_reg  <= out_valid_next;
            wait_reg       <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; d_reg <= d_next; r_reg <= r_next; i_reg <= i_next;
        e_reg <= e_next; b_reg <= b_next; acc_reg <= acc_next; k_reg <= k_next;
        base_reg <= base_next; prime_reg <= prime_next; out_reg <= out_next;
    end

    assign is_prime_valid = out_valid_reg;
    assign is_prime = out_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        is_prime_valid && !is_prime_ready |=> is_prime_valid && $stable(is_prime))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        candidate_valid && candidate_ready |=> !candidate_ready)
        else $error("accepted a candidate while busy");
    a_small: assert property (@(posedge clk) disable iff (!rst_n)
        candidate_valid && candidate_ready && candidate < W'(2) |=> state_reg == S_OUT)
        else $error("small candidate not rejected at once");
endmodule
`default_nettype wire

/* dv/tb_miller_rabin_primality_test.sv */
// Testbench for the Miller-Rabin primality tester: directed table, random candidates, predictor.
`timescale 1ns / 100ps
module tb_miller_rabin_primality_test;
    import mrpt_pkg::*;

    localparam int NW = NUMBER_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [NW-1:0] cand;
        bit            typed;
        bit            verdict;
    } prime_row_t;

    logic          clk;
    logic          rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [0:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          candidate_valid;
    logic          candidate_ready;
    logic [NW-1:0] candidate;
    logic          is_prime_valid;
    logic          is_prime_ready;
    logic          is_prime;

    bit            verdict_q[$];
    logic [5:0]    base_count_mirror;
    int            fail_count;
    int            cycle_count;
    bit            burst_mode;

    miller_rabin_primality_test #(.NUMBER_WIDTH(NW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .candidate_valid(candidate_valid), .candidate_ready(candidate_ready),
        .candidate(candidate),
        .is_prime_valid(is_prime_valid), .is_prime_ready(is_prime_ready),
        .is_prime(is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                               longint unsigned n);
        return (x * y) % n;
    endfunction

    function automatic bit witness_passes(longint unsigned n, longint unsigned base);
        longint unsigned a;
        longint unsigned d;
        longint unsigned x;
        longint unsigned b;
        longint unsigned e;
        int r;
        a = base % n;
        if (a <= 1)
            return 1'b1;
        d = n - 1;
        r = 0;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            r++;
        end
        x = 1;
        b = a;
        e = d;
        while (e != 0)
        begin
            if (e[0])
                x = mulmod(x, b, n);
            b = mulmod(b, b, n);
            e = e >> 1;
        end
        if (x == 1)
            return 1'b1;
        for (int i = 0; i < r; i++)
        begin
            if (x == n - 1)
                return 1'b1;
            x = mulmod(x, x, n);
        end
        return 1'b0;
    endfunction

    function automatic bit predict_prime(logic [NW-1:0] cand, logic [5:0] count);
        longint unsigned n;
        int bases;
        bit verdict;
        n = cand;
        bases = (count == 0) ? 1 : count;
        verdict = 1'b1;
        if (n < 2)
            return 1'b0;
        for (int k = 0; k < bases; k++)
            if (!witness_passes(n, FIRST_BASE + k))
                verdict = 1'b0;
        return verdict;
    endfunction

    task automatic apb_write_base_count(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'(ADDR_BASE_COUNT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        base_count_mirror = value[5:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[5:0] !== base_count_mirror)
        begin
            $display("%0t: base_count readback expected %0d actual %0d",
                     $time, base_count_mirror, prdata[5:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_candidate(input logic [NW-1:0] n, input bit typed, input bit verdict);
        int gap;
        if ($urandom_range(0, 9) == 0)
            burst_mode = ~burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            candidate_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        candidate       <= n;
        candidate_valid <= 1'b1;
        do
            @(posedge clk);
        while (!candidate_ready);
        verdict_q.push_back(typed ? verdict : predict_prime(n, base_count_mirror));
    endtask

    task automatic drain_results();
        candidate_valid <= 1'b0;
        while (verdict_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [NW-1:0] random_candidate();
        case ($urandom_range(0, 3))
            0: return NW'($urandom_range(0, 200));
            1: return NW'($urandom_range(0, 65535) | 1);
            2: return NW'($urandom() | 1);
            default: return NW'($urandom());
        endcase
    endfunction

    initial
    begin
        prime_row_t rows[$];
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        candidate_valid = 1'b0;
        candidate       = '0;
        fail_count      = 0;
        burst_mode      = 1'b0;
        base_count_mirror = BASE_COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{31'd0, 1'b1, 1'b0},
            '{31'd1, 1'b1, 1'b0},
            '{31'd2, 1'b1, 1'b1},
            '{31'h7FFFFFFF, 1'b1, 1'b1},
            '{31'h7FFFFFFE, 1'b1, 1'b0},
            '{31'd3, 1'b1, 1'b1},
            '{31'd4, 1'b1, 1'b0}
        };
        foreach (rows[i])
            send_candidate(rows[i].cand, rows[i].typed, rows[i].verdict);
        drain_results();

        apb_write_base_count(32);
        rows = '{
            '{31'd561, 1'b0, 1'b0},
            '{31'd2047, 1'b0, 1'b0},
            '{31'd31, 1'b0, 1'b0},
            '{31'd9, 1'b0, 1'b0}
        };
        foreach (rows[i])
            send_candidate(rows[i].cand, rows[i].typed, rows[i].verdict);
        drain_results();

        apb_write_base_count(0);
        rows = '{
            '{31'd2047, 1'b0, 1'b0},
            '{31'd1373653, 1'b0, 1'b0},
            '{31'd1, 1'b1, 1'b0},
            '{31'd7, 1'b0, 1'b0}
        };
        foreach (rows[i])
            send_candidate(rows[i].cand, rows[i].typed, rows[i].verdict);
        drain_results();

        apb_write_base_count(63);
        rows = '{
            '{31'd61, 1'b0, 1'b0},
            '{31'd65, 1'b0, 1'b0}
        };
        foreach (rows[i])
            send_candidate(rows[i].cand, rows[i].typed, rows[i].verdict);
        drain_results();

        apb_write_base_count(1);
        send_candidate(31'h7FFFFFFF, 1'b0, 1'b0);
        send_candidate(31'd2047, 1'b0, 1'b0);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            apb_write_base_count($urandom_range(1, 3));
            for (int i = 0; i < 31; i++)
                send_candidate(random_candidate(), 1'b0, 1'b0);
            drain_results();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        is_prime_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                is_prime_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            is_prime_ready <= 1'b1;
            do
                @(posedge clk);
            while (!is_prime_valid);
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0b", $time, is_prime);
                fail_count++;
            end
            else
            begin
                bit want;
                want = verdict_q.pop_front();
                if (is_prime !== want)
                begin
                    $display("%0t: is_prime expected %0b actual %0b", $time, want, is_prime);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end
endmodule
